### rtl/ttw_pkg.sv
`default_nettype none

package ttw_pkg;

  // Default screen geometry.
  localparam int MAX_COLS_DEF = 80;
  localparam int MAX_ROWS_DEF = 25;

  // Every linear position, product and loop bound fits in twelve bits, because the
  // column and row registers are seven and five bits wide.
  localparam int LIN_W  = 12;
  localparam int CELL_W = 16;
  localparam logic [10:0] LIN_MAX = 11'h7FF;

  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam int         TAB_STEP   = 4;

  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_HT = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [1:0] REG_COLUMNS    = 2'd0;
  localparam logic [1:0] REG_ROWS       = 2'd1;
  localparam logic [1:0] REG_TEXT_COLOR = 2'd2;
  localparam logic [1:0] REG_WRAP_OFF   = 2'd3;

  localparam logic [6:0] COLUMNS_RST    = 7'd80;
  localparam logic [4:0] ROWS_RST       = 5'd25;
  localparam logic [7:0] TEXT_COLOR_RST = 8'h07;

  // Program steps.
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] S_IDLE     = 5'd0;
  localparam logic [STEP_W-1:0] S_DISP     = 5'd1;
  localparam logic [STEP_W-1:0] S_P_ADDR   = 5'd2;
  localparam logic [STEP_W-1:0] S_P_CHAR   = 5'd3;
  localparam logic [STEP_W-1:0] S_P_WRAP   = 5'd4;
  localparam logic [STEP_W-1:0] S_P_CHK    = 5'd5;
  localparam logic [STEP_W-1:0] S_SC_INIT  = 5'd6;
  localparam logic [STEP_W-1:0] S_SC_COPY  = 5'd7;
  localparam logic [STEP_W-1:0] S_SC_BLANK = 5'd8;
  localparam logic [STEP_W-1:0] S_SC_DEC   = 5'd9;
  localparam logic [STEP_W-1:0] S_SET      = 5'd10;
  localparam logic [STEP_W-1:0] S_RD_ADDR  = 5'd11;
  localparam logic [STEP_W-1:0] S_RD_MEM   = 5'd12;
  localparam logic [STEP_W-1:0] S_RD_TAKE  = 5'd13;
  localparam logic [STEP_W-1:0] S_CLR_INIT = 5'd14;
  localparam logic [STEP_W-1:0] S_CLR_FILL = 5'd15;
  localparam logic [STEP_W-1:0] S_FIN_LIN  = 5'd16;
  localparam logic [STEP_W-1:0] S_FIN_OUT  = 5'd17;

  // Datapath actions.
  localparam int ACT_W = 4;
  localparam logic [ACT_W-1:0] A_IDLE     = 4'd0;
  localparam logic [ACT_W-1:0] A_NOP      = 4'd1;
  localparam logic [ACT_W-1:0] A_PUT_ADDR = 4'd2;
  localparam logic [ACT_W-1:0] A_PUT_CHAR = 4'd3;
  localparam logic [ACT_W-1:0] A_WRAP     = 4'd4;
  localparam logic [ACT_W-1:0] A_SCR_INIT = 4'd5;
  localparam logic [ACT_W-1:0] A_COPY     = 4'd6;
  localparam logic [ACT_W-1:0] A_FILL     = 4'd7;
  localparam logic [ACT_W-1:0] A_SCR_DEC  = 4'd8;
  localparam logic [ACT_W-1:0] A_SET      = 4'd9;
  localparam logic [ACT_W-1:0] A_RD_ADDR  = 4'd10;
  localparam logic [ACT_W-1:0] A_RD_TAKE  = 4'd11;
  localparam logic [ACT_W-1:0] A_CLR_INIT = 4'd12;
  localparam logic [ACT_W-1:0] A_LIN      = 4'd13;
  localparam logic [ACT_W-1:0] A_OUT      = 4'd14;

  // Sequencing conditions.
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] C_NEXT      = 3'd0;
  localparam logic [COND_W-1:0] C_JUMP      = 3'd1;
  localparam logic [COND_W-1:0] C_WAIT_ITEM = 3'd2;
  localparam logic [COND_W-1:0] C_DISPATCH  = 3'd3;
  localparam logic [COND_W-1:0] C_NO_SCROLL = 3'd4;
  localparam logic [COND_W-1:0] C_COPY      = 3'd5;
  localparam logic [COND_W-1:0] C_FILL      = 3'd6;
  localparam logic [COND_W-1:0] C_WAIT_OUT  = 3'd7;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  function automatic ctrl_word_t microcode(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w = '{act: A_IDLE, cond: C_WAIT_ITEM, target: S_IDLE};
    unique case (step)
      S_IDLE:     w = '{act: A_IDLE,     cond: C_WAIT_ITEM, target: S_IDLE};
      S_DISP:     w = '{act: A_NOP,      cond: C_DISPATCH,  target: S_IDLE};
      S_P_ADDR:   w = '{act: A_PUT_ADDR, cond: C_NEXT,      target: S_IDLE};
      S_P_CHAR:   w = '{act: A_PUT_CHAR, cond: C_NEXT,      target: S_IDLE};
      S_P_WRAP:   w = '{act: A_WRAP,     cond: C_NEXT,      target: S_IDLE};
      S_P_CHK:    w = '{act: A_NOP,      cond: C_NO_SCROLL, target: S_FIN_LIN};
      S_SC_INIT:  w = '{act: A_SCR_INIT, cond: C_NEXT,      target: S_IDLE};
      S_SC_COPY:  w = '{act: A_COPY,     cond: C_COPY,      target: S_SC_COPY};
      S_SC_BLANK: w = '{act: A_FILL,     cond: C_FILL,      target: S_SC_BLANK};
      S_SC_DEC:   w = '{act: A_SCR_DEC,  cond: C_JUMP,      target: S_P_CHK};
      S_SET:      w = '{act: A_SET,      cond: C_JUMP,      target: S_FIN_LIN};
      S_RD_ADDR:  w = '{act: A_RD_ADDR,  cond: C_NEXT,      target: S_IDLE};
      S_RD_MEM:   w = '{act: A_NOP,      cond: C_NEXT,      target: S_IDLE};
      S_RD_TAKE:  w = '{act: A_RD_TAKE,  cond: C_JUMP,      target: S_FIN_LIN};
      S_CLR_INIT: w = '{act: A_CLR_INIT, cond: C_NEXT,      target: S_IDLE};
      S_CLR_FILL: w = '{act: A_FILL,     cond: C_FILL,      target: S_CLR_FILL};
      S_FIN_LIN:  w = '{act: A_LIN,      cond: C_NEXT,      target: S_IDLE};
      S_FIN_OUT:  w = '{act: A_OUT,      cond: C_WAIT_OUT,  target: S_IDLE};
      default:    w = '{act: A_IDLE,     cond: C_WAIT_ITEM, target: S_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [STEP_W-1:0] dispatch(input logic [1:0] op);
    logic [STEP_W-1:0] s;
    unique case (op)
      OP_PUT:   s = S_P_ADDR;
      OP_SET:   s = S_SET;
      OP_CLEAR: s = S_CLR_INIT;
      OP_READ:  s = S_RD_ADDR;
      default:  s = S_IDLE;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### rtl/text_terminal_writer.sv
// Character-cell text terminal writer.
//
// Items arrive on the item channel (item_valid / item_stall) carrying operation, character,
// column and row; each item yields exactly one result word on the result channel
// (result_valid / result_stall). A word is accepted at a clock edge where valid is high and
// stall is low. Geometry, colour and the wrap switch are written through the cfg port, whose
// cfg_ready is always high; write it only while no item is in flight.
//
// A small microcode sequencer steps through a program in a constant table and works on
// one item at a time; item_stall is low only while the sequencer waits for an item.
// A put character may scroll the screen, more than once if needed. The scroll copy and
// the clear walk the screen store one cell per cycle through its single write port.
//
// A finished result sits in the output register while the next item is accepted; if the
// receiver holds result_stall, the following result waits in the sequencer until the
// register is free. Reset restores the register defaults and homes the cursor. The screen
// store is not cleared by reset: issue a clear before reading cells.

`default_nettype none

module text_terminal_writer #(
  parameter int MAX_COLS = ttw_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = ttw_pkg::MAX_ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [7:0]  character,
  input  wire logic [6:0]  column,
  input  wire logic [4:0]  row,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [7:0]       cell_char,
  output logic [7:0]       cell_color,
  output logic [6:0]       cursor_col,
  output logic [4:0]       cursor_row,
  output logic [10:0]      cursor_linear,
  output logic             scrolled,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = ttw_pkg::LIN_W;
  localparam int SW    = ttw_pkg::STEP_W;

  logic [SW-1:0]           pc, pc_next;
  ttw_pkg::ctrl_word_t     cw;

  logic [6:0] columns;
  logic [4:0] rows;
  logic [7:0] text_color;
  logic       wrap_off;
  logic [6:0] nc;
  logic [4:0] nr;

  logic [6:0] cx;
  logic [4:0] cy;
  logic [7:0] wx;
  logic [5:0] wy;

  logic [1:0] op_l;
  logic [7:0] ch_l;
  logic [6:0] col_l;
  logic [4:0] row_l;

  logic [LW-1:0] dst, src, lim, fill_end, prod;
  logic [10:0]   lin;
  logic          pv, rd_ok, scr_flag;
  logic [ttw_pkg::CELL_W-1:0] rd_cell, rdata, wdata;
  logic          we;
  logic [LW-1:0] raddr;
  logic [5:0]    mul_a;
  logic [7:0]    mul_c;
  logic          item_accept, out_busy, copy_done, fill_more, no_scroll, is_ctrl;

  assign cw          = ttw_pkg::microcode(pc);
  assign item_stall  = (pc != ttw_pkg::S_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign out_busy    = result_valid && result_stall;
  assign cfg_ready   = 1'b1;

  // Effective geometry: out-of-range register values are pulled into range.
  always_comb begin
    if (columns == '0) begin
      nc = 7'd1;
    end else if (32'(columns) > MAX_COLS) begin
      nc = 7'(MAX_COLS);
    end else begin
      nc = columns;
    end
    if (32'(rows) < 3) begin
      nr = 5'd3;
    end else if (32'(rows) > MAX_ROWS) begin
      nr = 5'(MAX_ROWS);
    end else begin
      nr = rows;
    end
  end

  // One shared multiply-add serves every address and bound calculation.
  always_comb begin
    mul_a = '0;
    mul_c = '0;
    unique case (cw.act)
      ttw_pkg::A_PUT_ADDR, ttw_pkg::A_LIN: begin
        mul_a = wy;
        mul_c = wx;
      end
      ttw_pkg::A_SCR_INIT: mul_a = 6'(nr) - 6'd3;
      ttw_pkg::A_CLR_INIT: mul_a = 6'(nr);
      ttw_pkg::A_RD_ADDR: begin
        mul_a = 6'(row_l);
        mul_c = 8'(col_l);
      end
      default: ;
    endcase
    prod = LW'(mul_a) * LW'(nc) + LW'(mul_c);
  end

  assign is_ctrl = (ch_l == ttw_pkg::CH_LF) || (ch_l == ttw_pkg::CH_CR) ||
                   (ch_l == ttw_pkg::CH_BS) || (ch_l == ttw_pkg::CH_HT) ||
                   (ch_l == ttw_pkg::CH_VT) || (ch_l == ttw_pkg::CH_FF);

  // The copy reads one cell ahead of the write, so the last write is the one that
  // lands on the final row-to-row position.
  assign copy_done = pv ? (dst + LW'(1) == lim) : (dst == lim);
  assign fill_more = (dst + LW'(1) != fill_end);
  assign no_scroll = wrap_off || (wy < 6'(nr) - 6'd2);

  always_comb begin
    pc_next = pc + SW'(1);
    unique case (cw.cond)
      ttw_pkg::C_NEXT:      ;
      ttw_pkg::C_JUMP:      pc_next = cw.target;
      ttw_pkg::C_WAIT_ITEM: if (!item_accept) pc_next = pc;
      ttw_pkg::C_DISPATCH:  pc_next = ttw_pkg::dispatch(op_l);
      ttw_pkg::C_NO_SCROLL: if (no_scroll) pc_next = cw.target;
      ttw_pkg::C_COPY:      if (!copy_done) pc_next = cw.target;
      ttw_pkg::C_FILL:      if (fill_more) pc_next = cw.target;
      ttw_pkg::C_WAIT_OUT:  pc_next = out_busy ? pc : cw.target;
      default:              pc_next = ttw_pkg::S_IDLE;
    endcase
  end

  // Screen store write side; every write goes to the address held in dst.
  always_comb begin
    we    = 1'b0;
    wdata = {text_color, ttw_pkg::BLANK_CHAR};
    raddr = (cw.act == ttw_pkg::A_COPY) ? src : dst;
    unique case (cw.act)
      ttw_pkg::A_PUT_CHAR: begin
        we    = !is_ctrl && (wx < 8'(nc)) && (wy < 6'(nr));
        wdata = {text_color, ch_l};
      end
      ttw_pkg::A_COPY: begin
        we    = pv;
        wdata = rdata;
      end
      ttw_pkg::A_FILL: we = 1'b1;
      default: ;
    endcase
  end

  ttw_screen #(
    .DEPTH (DEPTH)
  ) u_screen (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(dst)),
    .wdata (wdata),
    .raddr (AW'(raddr)),
    .rdata (rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= ttw_pkg::S_IDLE;
      result_valid <= 1'b0;
      cx           <= '0;
      cy           <= '0;
      columns      <= ttw_pkg::COLUMNS_RST;
      rows         <= ttw_pkg::ROWS_RST;
      text_color   <= ttw_pkg::TEXT_COLOR_RST;
      wrap_off     <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ttw_pkg::REG_COLUMNS:    columns    <= cfg_data[6:0];
          ttw_pkg::REG_ROWS:       rows       <= cfg_data[4:0];
          ttw_pkg::REG_TEXT_COLOR: text_color <= cfg_data;
          ttw_pkg::REG_WRAP_OFF:   wrap_off   <= cfg_data[0];
          default: ;
        endcase
      end
      if (cw.act == ttw_pkg::A_OUT && !out_busy) begin
        result_valid <= 1'b1;
        cx           <= wx[6:0];
        cy           <= wy[4:0];
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    unique case (cw.act)
      ttw_pkg::A_IDLE: begin
        if (item_accept) begin
          op_l     <= operation;
          ch_l     <= character;
          col_l    <= column;
          row_l    <= row;
          wx       <= (cx > nc) ? 8'(nc) : 8'(cx);
          wy       <= (cy > nr) ? 6'(nr) : 6'(cy);
          scr_flag <= 1'b0;
          rd_cell  <= '0;
        end
      end
      ttw_pkg::A_PUT_ADDR: dst <= prod;
      ttw_pkg::A_PUT_CHAR: begin
        unique case (ch_l)
          ttw_pkg::CH_LF: begin
            wx <= '0;
            wy <= wy + 6'd1;
          end
          ttw_pkg::CH_CR: wx <= '0;
          ttw_pkg::CH_BS: if (wx != '0) wx <= wx - 8'd1;
          ttw_pkg::CH_HT: wx <= wx + 8'(ttw_pkg::TAB_STEP);
          ttw_pkg::CH_VT: wy <= wy + 6'(ttw_pkg::TAB_STEP);
          ttw_pkg::CH_FF: wy <= wy + 6'd1;
          default:        wx <= wx + 8'd1;
        endcase
      end
      ttw_pkg::A_WRAP: begin
        if (!wrap_off) begin
          if (wx >= 8'(nc)) begin
            wx <= '0;
            wy <= wy + 6'd1;
          end
        end else begin
          if (wx > 8'(nc)) wx <= 8'(nc);
          if (wy > 6'(nr)) wy <= 6'(nr);
        end
      end
      ttw_pkg::A_SCR_INIT: begin
        lim      <= prod;
        fill_end <= prod + LW'(nc);
        dst      <= '0;
        src      <= LW'(nc);
        pv       <= 1'b0;
        scr_flag <= 1'b1;
      end
      ttw_pkg::A_COPY: begin
        if (src != fill_end) begin
          src <= src + LW'(1);
          pv  <= 1'b1;
        end else begin
          pv  <= 1'b0;
        end
        if (pv) dst <= dst + LW'(1);
      end
      ttw_pkg::A_FILL:    dst <= dst + LW'(1);
      ttw_pkg::A_SCR_DEC: wy  <= wy - 6'd1;
      ttw_pkg::A_SET: begin
        wx <= (col_l > nc) ? 8'(nc) : 8'(col_l);
        wy <= (row_l > nr) ? 6'(nr) : 6'(row_l);
      end
      ttw_pkg::A_RD_ADDR: begin
        dst   <= prod;
        rd_ok <= (col_l < nc) && (row_l < nr);
      end
      ttw_pkg::A_RD_TAKE: rd_cell <= rd_ok ? rdata : '0;
      ttw_pkg::A_CLR_INIT: begin
        dst      <= '0;
        fill_end <= prod;
        wx       <= '0;
        wy       <= '0;
      end
      ttw_pkg::A_LIN: lin <= (prod > LW'(ttw_pkg::LIN_MAX)) ? ttw_pkg::LIN_MAX : prod[10:0];
      ttw_pkg::A_OUT: begin
        if (!out_busy) begin
          cell_char     <= rd_cell[7:0];
          cell_color    <= rd_cell[15:8];
          cursor_col    <= wx[6:0];
          cursor_row    <= wy[4:0];
          cursor_linear <= lin;
          scrolled      <= scr_flag;
        end
      end
      default: ;
    endcase
  end

  // Every write to the screen store stays inside the visible geometry.
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    we |-> (dst < LW'(nr) * LW'(nc)))
    else $error("screen write beyond the visible area");

  // During the scroll copy the read address leads the write address by one row plus one.
  a_copy_lead: assert property (@(posedge clk) disable iff (rst)
    (cw.act == ttw_pkg::A_COPY && pv) |-> (src == dst + LW'(nc) + LW'(1)))
    else $error("scroll copy read and write addresses out of step");

  // A result is handed over and the sequencer returns to wait for the next word.
  a_commit: assert property (@(posedge clk) disable iff (rst)
    (cw.act == ttw_pkg::A_OUT && !out_busy) |=> (result_valid && pc == ttw_pkg::S_IDLE))
    else $error("result not presented after commit");

endmodule

`default_nettype wire

### rtl/ttw_screen.sv
`default_nettype none

module ttw_screen #(
  parameter int DEPTH = ttw_pkg::MAX_COLS_DEF * ttw_pkg::MAX_ROWS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [ttw_pkg::CELL_W-1:0]  wdata,
  input  wire logic [AW-1:0]               raddr,
  output logic      [ttw_pkg::CELL_W-1:0]  rdata
);

  logic [ttw_pkg::CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
